// ===== sv/scrs_pkg.sv =====
package scrs_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [2:0] PRED_EQ    = 3'd0;
  localparam logic [2:0] PRED_NE    = 3'd1;
  localparam logic [2:0] PRED_LT    = 3'd2;
  localparam logic [2:0] PRED_GE    = 3'd3;
  localparam logic [2:0] PRED_RANGE = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH,
    ST_EMIT1,
    ST_EMIT2
  } state_e;

  typedef struct packed {
    logic latch;
    logic update;
    logic init;
    logic step;
    logic emit_first;
    logic emit_second;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] command;
    logic       pred_ne;
    logic       search_done;
    logic       out_free;
  } stat_t;

endpackage

// ===== sv/sorted_column_range_search_unit.sv =====
// Sorted column of unsigned codes with lower-bound range queries. Items are
// taken one at a time: append and clear latch the item, then register the
// result once the result register is free; a query latches the item and
// sets up both searches, then the two lower-bound searches share the
// column RAM's single read port in turn, each step waiting for the
// registered read, and the result (two results for PRED_NE) is registered
// once the result register is free. The result register frees the input
// side while the last result of an item waits. Codes use the low CODE_BITS
// bits of the code fields; the column RAM needs no clearing after reset.
module sorted_column_range_search_unit #(
  parameter int DEPTH     = 1024,
  parameter int CODE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [2:0]                 predicate_i,
  input  logic [31:0]                code_lo_i,
  input  logic [31:0]                code_hi_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [$clog2(DEPTH+1)-1:0] range_first_o,
  output logic [$clog2(DEPTH+1)-1:0] range_end_o,
  output logic                       last_o
);

  scrs_pkg::ctrl_t ctrl;
  scrs_pkg::stat_t stat;

  scrs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .ctrl_o    (ctrl)
  );

  scrs_dpath #(
    .DEPTH    (DEPTH),
    .CODE_BITS(CODE_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .stat_o       (stat),
    .command_i    (command_i),
    .predicate_i  (predicate_i),
    .code_lo_i    (code_lo_i),
    .code_hi_i    (code_hi_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .range_first_o(range_first_o),
    .range_end_o  (range_end_o),
    .last_o       (last_o)
  );

endmodule

// ===== sv/scrs_ram.sv =====
module scrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scrs_ctrl.sv =====
module scrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  scrs_pkg::stat_t stat_i,
  output scrs_pkg::ctrl_t ctrl_o
);

  scrs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scrs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_stall_o = 1'b1;
    case (state_q)
      scrs_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.latch = 1'b1;
          state_d      = scrs_pkg::ST_EXEC;
        end
      end
      scrs_pkg::ST_EXEC: begin
        case (stat_i.command)
          scrs_pkg::CMD_APPEND, scrs_pkg::CMD_CLEAR: begin
            if (stat_i.out_free) begin
              ctrl_o.update = 1'b1;
              state_d       = scrs_pkg::ST_IDLE;
            end
          end
          scrs_pkg::CMD_QUERY: begin
            ctrl_o.init = 1'b1;
            state_d     = scrs_pkg::ST_SRCH;
          end
          default: begin
            state_d = scrs_pkg::ST_IDLE;
          end
        endcase
      end
      scrs_pkg::ST_SRCH: begin
        ctrl_o.step = 1'b1;
        if (stat_i.search_done) begin
          state_d = scrs_pkg::ST_EMIT1;
        end
      end
      scrs_pkg::ST_EMIT1: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_first = 1'b1;
          state_d = stat_i.pred_ne ? scrs_pkg::ST_EMIT2 : scrs_pkg::ST_IDLE;
        end
      end
      scrs_pkg::ST_EMIT2: begin
        if (stat_i.out_free) begin
          ctrl_o.emit_second = 1'b1;
          state_d            = scrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scrs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/scrs_dpath.sv =====
module scrs_dpath #(
  parameter int DEPTH     = 1024,
  parameter int CODE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  scrs_pkg::ctrl_t            ctrl_i,
  output scrs_pkg::stat_t            stat_o,
  input  logic [1:0]                 command_i,
  input  logic [2:0]                 predicate_i,
  input  logic [31:0]                code_lo_i,
  input  logic [31:0]                code_hi_i,
  input  logic                       out_stall_i,
  output logic                       out_valid_o,
  output logic [1:0]                 status_o,
  output logic [$clog2(DEPTH+1)-1:0] range_first_o,
  output logic [$clog2(DEPTH+1)-1:0] range_end_o,
  output logic                       last_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam logic [CODE_BITS-1:0] CODE_MAX = '1;

  logic [1:0]           cmd_q;
  logic [2:0]           pred_q;
  logic [CODE_BITS-1:0] lo_code_q, hi_code_q, last_code_q, last_code_d;
  logic [CODE_BITS-1:0] key_a_q, key_a_d, key_b_q, key_b_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     lo_a_q, lo_a_d, hi_a_q, hi_a_d;
  logic [CNT_W-1:0]     lo_b_q, lo_b_d, hi_b_q, hi_b_d;
  logic                 side_q, side_d, rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]     mid_a, mid_b, res_end;
  logic                 act_a, act_b, pred_known;
  logic                 ram_we;
  logic [CODE_BITS-1:0] rdata;
  logic                 out_valid_q, out_valid_d, out_load, out_free;
  logic [1:0]           status_q, status_d;
  logic [CNT_W-1:0]     first_q, first_d, end_q, end_d;
  logic                 last_q, last_d;
  logic                 is_full, is_below;

  assign act_a   = lo_a_q < hi_a_q;
  assign act_b   = lo_b_q < hi_b_q;
  assign mid_a   = lo_a_q + ((hi_a_q - lo_a_q) >> 1);
  assign mid_b   = lo_b_q + ((hi_b_q - lo_b_q) >> 1);
  assign res_end = (lo_b_q < lo_a_q) ? lo_a_q : lo_b_q;

  assign is_full  = count_q == CNT_W'(DEPTH);
  assign is_below = (count_q != '0) && (lo_code_q < last_code_q);
  assign ram_we   = ctrl_i.update && (cmd_q == scrs_pkg::CMD_APPEND) && !is_full && !is_below;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = ctrl_i.update || ctrl_i.emit_first || ctrl_i.emit_second;

  assign stat_o.command     = cmd_q;
  assign stat_o.pred_ne     = pred_q == scrs_pkg::PRED_NE;
  assign stat_o.search_done = !act_a && !act_b;
  assign stat_o.out_free    = out_free;

  scrs_ram #(
    .WIDTH(CODE_BITS),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(lo_code_q),
    .re_i   (ctrl_i.step),
    .raddr_i(side_q ? mid_b[AW-1:0] : mid_a[AW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      cmd_q     <= command_i;
      pred_q    <= predicate_i;
      lo_code_q <= code_lo_i[CODE_BITS-1:0];
      hi_code_q <= code_hi_i[CODE_BITS-1:0];
    end
    last_code_q <= last_code_d;
    key_a_q     <= key_a_d;
    key_b_q     <= key_b_d;
    lo_a_q      <= lo_a_d;
    hi_a_q      <= hi_a_d;
    lo_b_q      <= lo_b_d;
    hi_b_q      <= hi_b_d;
    side_q      <= side_d;
    rd_vld_q    <= rd_vld_d;
    status_q    <= status_d;
    first_q     <= first_d;
    end_q       <= end_d;
    last_q      <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    count_d     = count_q;
    last_code_d = last_code_q;
    if (ram_we) begin
      count_d     = count_q + CNT_W'(1);
      last_code_d = lo_code_q;
    end else if (ctrl_i.update && (cmd_q == scrs_pkg::CMD_CLEAR)) begin
      count_d = '0;
    end
  end

  always_comb begin
    key_a_d    = key_a_q;
    key_b_d    = key_b_q;
    lo_a_d     = lo_a_q;
    hi_a_d     = hi_a_q;
    lo_b_d     = lo_b_q;
    hi_b_d     = hi_b_q;
    side_d     = side_q;
    rd_vld_d   = rd_vld_q;
    pred_known = 1'b1;
    if (ctrl_i.init) begin
      case (pred_q)
        scrs_pkg::PRED_EQ, scrs_pkg::PRED_NE: begin
          key_a_d = lo_code_q;
          key_b_d = (lo_code_q == CODE_MAX) ? CODE_MAX : lo_code_q + CODE_BITS'(1);
        end
        scrs_pkg::PRED_LT: begin
          key_a_d = '0;
          key_b_d = lo_code_q;
        end
        scrs_pkg::PRED_GE: begin
          key_a_d = lo_code_q;
          key_b_d = CODE_MAX;
        end
        scrs_pkg::PRED_RANGE: begin
          key_a_d = lo_code_q;
          key_b_d = hi_code_q;
        end
        default: begin
          key_a_d    = '0;
          key_b_d    = '0;
          pred_known = 1'b0;
        end
      endcase
      lo_a_d   = '0;
      hi_a_d   = (pred_known && key_a_d != '0) ? count_q : '0;
      lo_b_d   = (pred_known && key_b_d == CODE_MAX) ? count_q : '0;
      hi_b_d   = pred_known ? count_q : '0;
      side_d   = 1'b0;
      rd_vld_d = 1'b0;
    end else if (ctrl_i.step) begin
      side_d   = !side_q;
      rd_vld_d = 1'b1;
      if (rd_vld_q && !side_q && act_b) begin
        if (rdata < key_b_q) begin
          lo_b_d = mid_b + CNT_W'(1);
        end else begin
          hi_b_d = mid_b;
        end
      end
      if (rd_vld_q && side_q && act_a) begin
        if (rdata < key_a_q) begin
          lo_a_d = mid_a + CNT_W'(1);
        end else begin
          hi_a_d = mid_a;
        end
      end
    end
  end

  always_comb begin
    status_d = status_q;
    first_d  = first_q;
    end_d    = end_q;
    last_d   = last_q;
    if (ctrl_i.update) begin
      status_d = scrs_pkg::STAT_OK;
      if (cmd_q == scrs_pkg::CMD_APPEND) begin
        if (is_full) begin
          status_d = scrs_pkg::STAT_FULL;
        end else if (is_below) begin
          status_d = scrs_pkg::STAT_ORDER;
        end
      end
      first_d = '0;
      end_d   = '0;
      last_d  = 1'b1;
    end else if (ctrl_i.emit_first) begin
      status_d = scrs_pkg::STAT_OK;
      if (pred_q == scrs_pkg::PRED_NE) begin
        first_d = '0;
        end_d   = lo_a_q;
        last_d  = 1'b0;
      end else begin
        first_d = lo_a_q;
        end_d   = res_end;
        last_d  = 1'b1;
      end
    end else if (ctrl_i.emit_second) begin
      status_d = scrs_pkg::STAT_OK;
      first_d  = res_end;
      end_d    = count_q;
      last_d   = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign range_first_o = first_q;
  assign range_end_o   = end_q;
  assign last_o        = last_q;

endmodule

// ===== sv/scrs_checker.sv =====
module scrs_checker #(
  parameter int CNT_W = 11
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [1:0]       status_o,
  input logic [CNT_W-1:0] range_first_o,
  input logic [CNT_W-1:0] range_end_o,
  input logic             last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(range_first_o)
      && $stable(range_end_o) && $stable(status_o) && $stable(last_o))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while an item is in progress");

  a_second_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o && last_o)
    else $error("second result did not follow the first");

  a_flag_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != scrs_pkg::STAT_OK) |->
      range_first_o == '0 && range_end_o == '0 && last_o)
    else $error("flagged append with a non-empty range");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind sorted_column_range_search_unit scrs_checker #(
  .CNT_W($bits(range_first_o))
) u_scrs_checker (.*);
